>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands, reset-qualified on rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lnpd_pkg.sv
// ----------------------------------------------------------------------------
// lnpd_pkg
// Shared widths, codes and types of the per-label nearest distance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lnpd_pkg;

  localparam int MAX_LABELS_DEF = 256;
  localparam int COORD_BITS_DEF = 12;

  localparam int PIX_BITS      = 12;
  localparam int LABEL_BITS    = 8;
  localparam int COUNT_BITS    = 9;
  localparam int DIST_BITS     = 31;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [DIST_BITS-1:0] INT_MAX = 31'h7FFF_FFFF;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_PIXEL  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LABEL_COUNT = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EMPTY_LABEL = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_status_t;

endpackage

>>> rtl/label_nearest_pixel_distance.sv
// ----------------------------------------------------------------------------
// label_nearest_pixel_distance
// Per-label minimum squared distance to a center point, read back as
// floor(sqrt(min)), or the all-ones 31-bit value when nothing was recorded.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/in_* and are taken when start is high and busy
//   is low. Operations: clear (all entries empty), pixel update, read.
//   A clear, an unused code, or a pixel with the empty label or an
//   untracked label completes at once; busy stays low.
//   A pixel update holds busy through ST_PX_RD, which forms the squares,
//   then ST_PX_WR, which compares and writes back into the minimum RAM;
//   the RAM read is issued with the request.
//   A read gives one out_valid strobe: from ST_RD_MEM for an empty entry,
//   from ST_RD_SQRT for a recorded one once the one-bit-per-cycle square
//   root unit (COORD_BITS+1 root bits, COORD_BITS capped at 12) is done.
//   Busy drops in the strobe cycle.
//   The receiver cannot stall; each result is shown for one cycle only.
//   Configuration writes on cfg_* are always ready and take effect next
//   cycle; they are meant for idle periods and do not clear the minima.
//   Reset (synchronous rst_n low) empties all entries and loads register
//   defaults; no clearing pass over the RAM is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module label_nearest_pixel_distance #(
  parameter int MAX_LABELS = lnpd_pkg::MAX_LABELS_DEF,
  parameter int COORD_BITS = lnpd_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_operation,
  input  logic [lnpd_pkg::PIX_BITS-1:0]      in_pixel_x,
  input  logic [lnpd_pkg::PIX_BITS-1:0]      in_pixel_y,
  input  logic [lnpd_pkg::LABEL_BITS-1:0]    in_label,
  output logic                               out_valid,
  output logic [lnpd_pkg::DIST_BITS-1:0]     out_distance,
  output logic                               out_seen,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lnpd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lnpd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CB    = (COORD_BITS < lnpd_pkg::PIX_BITS) ? COORD_BITS : lnpd_pkg::PIX_BITS;
  localparam int SQ_W  = 2 * CB + 1;
  localparam int RW    = CB + 1;
  localparam int IDX_W = $clog2(MAX_LABELS);
  localparam logic [lnpd_pkg::COUNT_BITS-1:0] MAX_CNT = lnpd_pkg::COUNT_BITS'(MAX_LABELS);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_PX_RD   = 5'b00010,
    ST_PX_WR   = 5'b00100,
    ST_RD_MEM  = 5'b01000,
    ST_RD_SQRT = 5'b10000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [MAX_LABELS-1:0]               valid_r, valid_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [lnpd_pkg::PIX_BITS-1:0]       center_x_r, center_x_nxt;
  logic [lnpd_pkg::PIX_BITS-1:0]       center_y_r, center_y_nxt;
  logic [lnpd_pkg::COUNT_BITS-1:0]     label_count_r, label_count_nxt;
  logic [lnpd_pkg::LABEL_BITS-1:0]     empty_label_r, empty_label_nxt;

  logic [IDX_W-1:0]                    idx_r, idx_nxt;
  logic [CB-1:0]                       dx_r, dx_nxt;
  logic [CB-1:0]                       dy_r, dy_nxt;
  logic [SQ_W-1:0]                     sq_r, sq_nxt;
  logic                                seen_r, seen_nxt;
  logic [lnpd_pkg::DIST_BITS-1:0]      out_distance_r, out_distance_nxt;
  logic                                out_seen_r, out_seen_nxt;

  logic                                accept;
  logic [IDX_W-1:0]                    in_idx;
  logic                                in_range;
  logic [CB-1:0]                       px, py, cx, cy;
  logic [2*CB-1:0]                     dx2, dy2;
  logic                                better;

  logic                                mem_re;
  logic                                mem_we;
  logic [SQ_W-1:0]                     mem_rdata;

  logic                                sq_start;
  logic [RW-1:0]                       sq_root;
  lnpd_pkg::sqrt_status_t              sq_st;

  assign accept   = start && (state_r == ST_IDLE);
  assign in_idx   = in_label[IDX_W-1:0];
  assign in_range = ({1'b0, in_label} < label_count_r) && ({1'b0, in_label} < MAX_CNT);
  assign px       = in_pixel_x[CB-1:0];
  assign py       = in_pixel_y[CB-1:0];
  assign cx       = center_x_r[CB-1:0];
  assign cy       = center_y_r[CB-1:0];
  assign dx2      = dx_r * dx_r;
  assign dy2      = dy_r * dy_r;
  assign better   = !valid_r[idx_r] || (sq_r < mem_rdata);

  assign mem_re   = accept && ((in_operation == lnpd_pkg::OP_PIXEL) ||
                               (in_operation == lnpd_pkg::OP_READ));
  assign mem_we   = (state_r == ST_PX_WR) && better;
  assign sq_start = (state_r == ST_RD_MEM) && seen_r;

  lnpd_mem #(
    .DEPTH (MAX_LABELS),
    .WIDTH (SQ_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_r),
    .wdata (sq_r),
    .re    (mem_re),
    .raddr (in_idx),
    .rdata (mem_rdata)
  );

  lnpd_isqrt #(
    .ROOT_BITS (RW)
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .value  ({1'b0, mem_rdata}),
    .root   (sq_root),
    .status (sq_st)
  );

  always_comb begin
    state_nxt        = state_r;
    valid_nxt        = valid_r;
    out_valid_nxt    = 1'b0;
    center_x_nxt     = center_x_r;
    center_y_nxt     = center_y_r;
    label_count_nxt  = label_count_r;
    empty_label_nxt  = empty_label_r;
    idx_nxt          = idx_r;
    dx_nxt           = dx_r;
    dy_nxt           = dy_r;
    sq_nxt           = sq_r;
    seen_nxt         = seen_r;
    out_distance_nxt = out_distance_r;
    out_seen_nxt     = out_seen_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lnpd_pkg::CFG_CENTER_X:    center_x_nxt    = cfg_data;
        lnpd_pkg::CFG_CENTER_Y:    center_y_nxt    = cfg_data;
        lnpd_pkg::CFG_LABEL_COUNT: label_count_nxt = cfg_data[lnpd_pkg::COUNT_BITS-1:0];
        lnpd_pkg::CFG_EMPTY_LABEL: empty_label_nxt = cfg_data[lnpd_pkg::LABEL_BITS-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt = in_idx;
          dx_nxt  = (px >= cx) ? (px - cx) : (cx - px);
          dy_nxt  = (py >= cy) ? (py - cy) : (cy - py);
          case (in_operation)
            lnpd_pkg::OP_CLEAR: valid_nxt = '0;
            lnpd_pkg::OP_PIXEL: begin
              if (in_range && (in_label != empty_label_r)) begin
                state_nxt = ST_PX_RD;
              end
            end
            lnpd_pkg::OP_READ: begin
              seen_nxt  = in_range && valid_r[in_idx];
              state_nxt = ST_RD_MEM;
            end
            default: ;
          endcase
        end
      end
      ST_PX_RD: begin
        sq_nxt    = {1'b0, dx2} + {1'b0, dy2};
        state_nxt = ST_PX_WR;
      end
      ST_PX_WR: begin
        if (better) begin
          valid_nxt[idx_r] = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_RD_MEM: begin
        if (seen_r) begin
          state_nxt = ST_RD_SQRT;
        end else begin
          out_valid_nxt    = 1'b1;
          out_distance_nxt = lnpd_pkg::INT_MAX;
          out_seen_nxt     = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end
      ST_RD_SQRT: begin
        if (sq_st.done && !sq_st.busy) begin
          out_valid_nxt    = 1'b1;
          out_distance_nxt = lnpd_pkg::DIST_BITS'(sq_root);
          out_seen_nxt     = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
      center_x_r    <= '0;
      center_y_r    <= '0;
      label_count_r <= lnpd_pkg::COUNT_BITS'(256);
      empty_label_r <= lnpd_pkg::LABEL_BITS'(255);
    end else begin
      state_r       <= state_nxt;
      valid_r       <= valid_nxt;
      out_valid_r   <= out_valid_nxt;
      center_x_r    <= center_x_nxt;
      center_y_r    <= center_y_nxt;
      label_count_r <= label_count_nxt;
      empty_label_r <= empty_label_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r          <= idx_nxt;
    dx_r           <= dx_nxt;
    dy_r           <= dy_nxt;
    sq_r           <= sq_nxt;
    seen_r         <= seen_nxt;
    out_distance_r <= out_distance_nxt;
    out_seen_r     <= out_seen_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_seen     = out_seen_r;

endmodule

>>> rtl/lnpd_mem.sv
// ----------------------------------------------------------------------------
// lnpd_mem
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lnpd_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lnpd_isqrt.sv
// ----------------------------------------------------------------------------
// lnpd_isqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lnpd_isqrt #(
  parameter int ROOT_BITS = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [2*ROOT_BITS-1:0]     value,
  output logic [ROOT_BITS-1:0]       root,
  output lnpd_pkg::sqrt_status_t     status
);

  localparam int VAL_W = 2 * ROOT_BITS;
  localparam int REM_W = ROOT_BITS + 2;
  localparam int CNT_W = $clog2(ROOT_BITS + 1);

  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [ROOT_BITS-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [REM_W-1:0]     rem_sh;
  logic [REM_W-1:0]     trial;

  assign rem_sh = {rem_r[ROOT_BITS-1:0], val_r[VAL_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      val_nxt  = value;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(ROOT_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[VAL_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root        = root_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

>>> rtl/lnpd_checker.sv
// ----------------------------------------------------------------------------
// lnpd_checker
// Port-level checks of the nearest distance block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lnpd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [1:0]                     in_operation,
  input logic                           out_valid,
  input logic [lnpd_pkg::DIST_BITS-1:0] out_distance,
  input logic                           out_seen
);

  `CHK_IMPLY(a_unseen_max, out_valid && !out_seen, out_distance == lnpd_pkg::INT_MAX, "unseen read must give max distance")
  `CHK_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `CHK_NEXT(a_read_busy, start && !busy && (in_operation == lnpd_pkg::OP_READ), busy, "read request did not raise busy")
  `CHK_NEXT(a_clear_idle, start && !busy && (in_operation == lnpd_pkg::OP_CLEAR || in_operation == lnpd_pkg::OP_UNUSED), !busy, "clear or unused code raised busy")
  `CHK_IMPLY(a_strobe_idle, out_valid, !busy, "busy high during result strobe")

endmodule

bind label_nearest_pixel_distance lnpd_checker u_lnpd_checker (.*);

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks per-label nearest pixel distance: a tracker class predicts every
// read answer from the accepted requests and register writes, and compares
// it with each out_valid strobe. Directed corner requests come first, then
// random phases under changing center, label count and empty label settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [lnpd_pkg::DIST_BITS-1:0] distance;
    logic                           seen;
  } read_answer_t;

  class label_distance_tracker;
    logic [lnpd_pkg::PIX_BITS-1:0]   center_x;
    logic [lnpd_pkg::PIX_BITS-1:0]   center_y;
    logic [lnpd_pkg::COUNT_BITS-1:0] label_count;
    logic [lnpd_pkg::LABEL_BITS-1:0] empty_label;
    logic [24:0]                     min_sq [256];
    bit                              recorded [256];
    read_answer_t                    pending_reads [$];
    int                              errors;

    function new();
      center_x    = '0;
      center_y    = '0;
      label_count = 9'd256;
      empty_label = 8'd255;
      foreach (recorded[i]) begin
        recorded[i] = 1'b0;
        min_sq[i]   = '0;
      end
      errors = 0;
    endfunction

    function void note_config(logic [lnpd_pkg::CFG_IDX_BITS-1:0] idx,
                              logic [lnpd_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        lnpd_pkg::CFG_CENTER_X:    center_x    = data;
        lnpd_pkg::CFG_CENTER_Y:    center_y    = data;
        lnpd_pkg::CFG_LABEL_COUNT: label_count = data[lnpd_pkg::COUNT_BITS-1:0];
        lnpd_pkg::CFG_EMPTY_LABEL: empty_label = data[lnpd_pkg::LABEL_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [24:0] floor_sqrt(logic [24:0] v);
      logic [24:0] root;
      logic [49:0] trial;
      root = '0;
      for (int b = 12; b >= 0; b--) begin
        trial = 50'(root | (25'd1 << b));
        if (trial * trial <= 50'(v)) root = root | (25'd1 << b);
      end
      return root;
    endfunction

    function void note_request(logic [1:0] op, logic [lnpd_pkg::PIX_BITS-1:0] x,
                               logic [lnpd_pkg::PIX_BITS-1:0] y,
                               logic [lnpd_pkg::LABEL_BITS-1:0] lab);
      logic [24:0]  dx;
      logic [24:0]  dy;
      logic [24:0]  sq;
      bit           tracked;
      read_answer_t ans;
      tracked = {1'b0, lab} < label_count;
      case (op)
        lnpd_pkg::OP_CLEAR: begin
          foreach (recorded[i]) recorded[i] = 1'b0;
        end
        lnpd_pkg::OP_PIXEL: begin
          if (lab != empty_label && tracked) begin
            dx = (x > center_x) ? 25'(x - center_x) : 25'(center_x - x);
            dy = (y > center_y) ? 25'(y - center_y) : 25'(center_y - y);
            sq = dx * dx + dy * dy;
            if (!recorded[lab] || sq < min_sq[lab]) begin
              min_sq[lab]   = sq;
              recorded[lab] = 1'b1;
            end
          end
        end
        lnpd_pkg::OP_READ: begin
          if (tracked && recorded[lab]) begin
            ans.distance = lnpd_pkg::DIST_BITS'(floor_sqrt(min_sq[lab]));
            ans.seen     = 1'b1;
          end else begin
            ans.distance = lnpd_pkg::INT_MAX;
            ans.seen     = 1'b0;
          end
          pending_reads.push_back(ans);
        end
        default: ;
      endcase
    endfunction

    function void check_read(logic [lnpd_pkg::DIST_BITS-1:0] distance, logic seen);
      read_answer_t ans;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected read answer distance=%0d seen=%0b", $time, distance, seen);
        errors++;
        return;
      end
      ans = pending_reads.pop_front();
      if (distance !== ans.distance) begin
        $display("%0t: distance mismatch expected=%0d actual=%0d", $time, ans.distance,
                 distance);
        errors++;
      end
      if (seen !== ans.seen) begin
        $display("%0t: seen mismatch expected=%0b actual=%0b", $time, ans.seen, seen);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 300000;

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic [1:0]                         in_operation;
  logic [lnpd_pkg::PIX_BITS-1:0]      in_pixel_x;
  logic [lnpd_pkg::PIX_BITS-1:0]      in_pixel_y;
  logic [lnpd_pkg::LABEL_BITS-1:0]    in_label;
  logic                               out_valid;
  logic [lnpd_pkg::DIST_BITS-1:0]     out_distance;
  logic                               out_seen;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [lnpd_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [lnpd_pkg::CFG_DATA_BITS-1:0] cfg_data;

  label_distance_tracker tracker;
  int cycles;

  label_nearest_pixel_distance uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_operation(in_operation),
    .in_pixel_x  (in_pixel_x),
    .in_pixel_y  (in_pixel_y),
    .in_label    (in_label),
    .out_valid   (out_valid),
    .out_distance(out_distance),
    .out_seen    (out_seen),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_read(out_distance, out_seen);
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start        = 1'b0;
      in_operation = 2'($urandom);
      in_pixel_x   = lnpd_pkg::PIX_BITS'($urandom);
      in_pixel_y   = lnpd_pkg::PIX_BITS'($urandom);
      in_label     = lnpd_pkg::LABEL_BITS'($urandom);
    end
  endtask

  task automatic send_request(logic [1:0] op, logic [lnpd_pkg::PIX_BITS-1:0] x,
                              logic [lnpd_pkg::PIX_BITS-1:0] y,
                              logic [lnpd_pkg::LABEL_BITS-1:0] lab);
    @(negedge clk);
    start        = 1'b1;
    in_operation = op;
    in_pixel_x   = x;
    in_pixel_y   = y;
    in_label     = lab;
    do @(posedge clk); while (busy);
    tracker.note_request(op, x, y, lab);
  endtask

  // drain outstanding reads, then let a pixel write-back finish
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (tracker.pending_reads.size() != 0 || busy) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_register(logic [lnpd_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [lnpd_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.note_config(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [11:0] cx, logic [11:0] cy, logic [8:0] count,
                           logic [7:0] empty);
    settle();
    write_register(lnpd_pkg::CFG_CENTER_X, cx);
    write_register(lnpd_pkg::CFG_CENTER_Y, cy);
    write_register(lnpd_pkg::CFG_LABEL_COUNT, {3'd0, count});
    write_register(lnpd_pkg::CFG_EMPTY_LABEL, {4'd0, empty});
  endtask

  function automatic logic [11:0] pick_center();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'hFFF;
    return 12'($urandom);
  endfunction

  function automatic logic [8:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd2;
      3, 4: return 9'd256;
      5: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(3, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_empty();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 8'd0;
    if (r <= 2) return 8'd255;
    return 8'($urandom);
  endfunction

  task automatic random_phase(int n_items, bit back_to_back);
    int          r;
    int          lim;
    logic [1:0]  op;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  lab;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) op = lnpd_pkg::OP_CLEAR;
      else if (r < 6) op = lnpd_pkg::OP_UNUSED;
      else if (r < 28) op = lnpd_pkg::OP_READ;
      else op = lnpd_pkg::OP_PIXEL;
      lim = (tracker.label_count > 256) ? 256 : int'(tracker.label_count);
      r = $urandom_range(0, 99);
      if (lim == 0 || r >= 85) lab = 8'($urandom);
      else if (r < 45) lab = 8'($urandom_range(0, (lim < 8 ? lim : 8) - 1));
      else lab = 8'($urandom_range(0, lim - 1));
      if ($urandom_range(0, 9) < 7) begin
        x = 12'($urandom);
        y = 12'($urandom);
      end else begin
        x = tracker.center_x + 12'($urandom_range(0, 6)) - 12'd3;
        y = tracker.center_y + 12'($urandom_range(0, 6)) - 12'd3;
      end
      if (!back_to_back) idle_for(gap_length());
      send_request(op, x, y, lab);
    end
  endtask

  initial begin
    tracker      = new();
    cycles       = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = lnpd_pkg::OP_CLEAR;
    in_pixel_x   = '0;
    in_pixel_y   = '0;
    in_label     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = lnpd_pkg::CFG_CENTER_X;
    cfg_data     = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // defaults: center at origin, 256 labels, empty label 255
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd3);   // read before any clear
    send_request(lnpd_pkg::OP_PIXEL,  12'hFFF, 12'hFFF, 8'd0);   // largest distance
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd0);
    send_request(lnpd_pkg::OP_PIXEL,  12'd7,   12'd9,   8'd255); // empty label
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd255);
    send_request(lnpd_pkg::OP_UNUSED, 12'hA5A, 12'h5A5, 8'd1);
    send_request(lnpd_pkg::OP_PIXEL,  12'd0,   12'd0,   8'd1);
    send_request(lnpd_pkg::OP_PIXEL,  12'd30,  12'd40,  8'd1);   // farther, keeps zero
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd1);
    send_request(lnpd_pkg::OP_CLEAR,  12'd0,   12'd0,   8'd0);
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd0);
    send_request(lnpd_pkg::OP_PIXEL,  12'hFFF, 12'd0,   8'd254);
    send_request(lnpd_pkg::OP_PIXEL,  12'd3,   12'd4,   8'd2);
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd254);
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd2);

    // single tracked label which is also the empty label
    configure(12'hFFF, 12'hFFF, 9'd1, 8'd0);
    send_request(lnpd_pkg::OP_PIXEL,  12'd0,   12'd0,   8'd0);
    send_request(lnpd_pkg::OP_PIXEL,  12'd0,   12'd0,   8'd1);
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd1);
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd0);

    // no labels tracked, then a count beyond the table; minima survive
    configure(12'hFFF, 12'hFFF, 9'd0, 8'd255);
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd254);
    send_request(lnpd_pkg::OP_PIXEL,  12'd1,   12'd1,   8'd0);
    configure(12'd0, 12'd0, 9'd511, 8'd255);
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd254);
    send_request(lnpd_pkg::OP_PIXEL,  12'd0,   12'hFFF, 8'd254);
    send_request(lnpd_pkg::OP_READ,   12'd0,   12'd0,   8'd254);

    configure(12'd2048, 12'd1024, 9'd256, 8'd255);
    random_phase(48, 1'b1);
    for (int p = 0; p < 7; p++) begin
      configure(pick_center(), pick_center(), pick_count(), pick_empty());
      random_phase(48, $urandom_range(0, 3) == 0);
    end

    @(negedge clk);
    start = 1'b0;
    while (tracker.pending_reads.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
